// ===== hdl/c1ks_pkg.sv =====
// Shared types, constants and filter functions of the Crypto1 keystream unit.
package c1ks_pkg;

	localparam int HALF_W = 24;
	localparam int KEY_W  = 48;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;

	// Operation codes.
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_BIT   = 3'd2;
	localparam logic [2:0] OP_BYTE  = 3'd3;
	localparam logic [2:0] OP_WORD  = 3'd4;

	// Step count minus one, loaded at the start of each clocked operation.
	localparam logic [CNT_W-1:0] STEPS_BIT  = CNT_W'(0);
	localparam logic [CNT_W-1:0] STEPS_BYTE = CNT_W'(7);
	localparam logic [CNT_W-1:0] STEPS_WORD = CNT_W'(31);

	// Feedback polynomial taps of the two halves.
	localparam logic [HALF_W-1:0] TAPS_ODD  = 24'h29CE5C;
	localparam logic [HALF_W-1:0] TAPS_EVEN = 24'h870804;

	// First-level filter tables and the second-level output table.
	localparam logic [19:0] FILT_A   = 20'hF22C0;
	localparam logic [19:0] FILT_B   = 20'h6C9C0;
	localparam logic [19:0] FILT_C   = 20'h3C8B0;
	localparam logic [19:0] FILT_D   = 20'h1E458;
	localparam logic [19:0] FILT_E   = 20'h0D938;
	localparam logic [31:0] FILT_OUT = 32'hEC57E80A;

	// Control of the cipher register for one cycle.
	typedef struct packed {
		logic clear;
		logic load;
		logic step;
	} lfsr_ctl_t;

	// Control of the serial data registers for one cycle.
	typedef struct packed {
		logic load;
		logic shift;
	} ser_ctl_t;

	// Two-level nonlinear filter over the low 20 bits of the odd half.
	function automatic logic filter_bit(input logic [19:0] x);
		logic [19:0] ta;
		logic [19:0] tb;
		logic [19:0] tc;
		logic [19:0] td;
		logic [19:0] te;
		logic [4:0]  sel;
		logic [31:0] tf;
		ta  = FILT_A >> x[3:0];
		tb  = FILT_B >> x[7:4];
		tc  = FILT_C >> x[11:8];
		td  = FILT_D >> x[15:12];
		te  = FILT_E >> x[19:16];
		sel = {ta[4], tb[3], tc[2], td[1], te[0]};
		tf  = FILT_OUT >> sel;
		return tf[0];
	endfunction

	// Odd half after a key load: bit j takes key bit (2j) xor 7.
	function automatic logic [HALF_W-1:0] key_odd(input logic [KEY_W-1:0] key);
		logic [HALF_W-1:0] o;
		logic [5:0]        idx;
		o = '0;
		for (int j = 0; j < HALF_W; j++) begin
			idx  = 6'(2 * j) ^ 6'd7;
			o[j] = key[idx];
		end
		return o;
	endfunction

	// Even half after a key load: bit j takes key bit (2j+1) xor 7.
	function automatic logic [HALF_W-1:0] key_even(input logic [KEY_W-1:0] key);
		logic [HALF_W-1:0] e;
		logic [5:0]        idx;
		e = '0;
		for (int j = 0; j < HALF_W; j++) begin
			idx  = 6'(2 * j + 1) ^ 6'd7;
			e[j] = key[idx];
		end
		return e;
	endfunction

	// Reverse the byte order of a word.
	function automatic logic [DATA_W-1:0] byte_swap(input logic [DATA_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

// ===== hdl/crypto1_keystream_cipher_unit.sv =====
// Top level of the Crypto1 keystream unit: sequencer, key register, result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------
//   input    | in_valid / in_stall       | op, feed_in, encrypted_feedback, xor_data
//   output   | out_valid / out_stall     | data_out
//   config   | cfg_wr_en                 | cfg_wr_data (cipher key)
//
// One cipher step runs per cycle through the single cipher register. A bit,
// byte or word operation passes through the run state and then the flush
// state; clear, key load and unused codes go from idle straight to flush.
// Reset clears the cipher register, the key and all control state.
// A stalled output holds the finished transaction in the flush state; the
// input side stalls until that result moves into the output register.
module crypto1_keystream_cipher_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [c1ks_pkg::KEY_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  op,
	input  logic [c1ks_pkg::DATA_W-1:0] feed_in,
	input  logic                        encrypted_feedback,
	input  logic [c1ks_pkg::DATA_W-1:0] xor_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [c1ks_pkg::DATA_W-1:0] data_out
);
	import c1ks_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              enc_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] data_out_q;
	logic [KEY_W-1:0]  key_q;

	logic              accept;
	logic              out_free;
	logic              flush_done;
	lfsr_ctl_t         lctl;
	ser_ctl_t          sctl;
	logic              ks_bit;
	logic              feed_bit;
	logic [DATA_W-1:0] result;

	// Key register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr_en) begin
			key_q <= cfg_wr_data;
		end
	end

	// Handshake and per-cycle control of the datapath.
	always_comb begin
		accept     = in_valid && (state_q == ST_IDLE);
		out_free   = !out_valid_q || !out_stall;
		flush_done = (state_q == ST_FLUSH) && out_free;
		lctl.clear = accept && (op == OP_CLEAR);
		lctl.load  = accept && (op == OP_LOAD);
		lctl.step  = (state_q == ST_RUN);
		sctl.load  = accept;
		sctl.shift = (state_q == ST_RUN);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

	c1ks_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lctl),
		.key    (key_q),
		.in_bit (feed_bit),
		.enc    (enc_q),
		.ks_bit (ks_bit)
	);

	c1ks_serial u_serial (
		.clk      (clk),
		.ctl      (sctl),
		.op       (op),
		.feed_in  (feed_in),
		.xor_data (xor_data),
		.ks_bit   (ks_bit),
		.feed_bit (feed_bit),
		.result   (result)
	);

	// Sequencer with the step counter and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			enc_q       <= 1'b0;
			out_valid_q <= 1'b0;
			data_out_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						enc_q <= encrypted_feedback;
						priority if (op == OP_BIT) begin
							cnt_q   <= STEPS_BIT;
							state_q <= ST_RUN;
						end else if (op == OP_BYTE) begin
							cnt_q   <= STEPS_BYTE;
							state_q <= ST_RUN;
						end else if (op == OP_WORD) begin
							cnt_q   <= STEPS_WORD;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (flush_done) begin
				out_valid_q <= 1'b1;
				data_out_q  <= result;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// An accepted transaction keeps the input side stalled in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted transaction");

	// A new result appears only out of the flush state.
	a_result_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_FLUSH))
		else $error("result register loaded outside the flush state");

	// A finished transaction waits while the output register is full and stalled.
	a_flush_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FLUSH) && out_valid && out_stall) |=> (state_q == ST_FLUSH))
		else $error("finished transaction left flush while output was stalled");

	// A bit operation runs for exactly one step.
	a_bit_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && ($past(state_q) == ST_IDLE) && $past(op == OP_BIT))
		|=> (state_q == ST_FLUSH))
		else $error("bit operation ran more than one step");
`endif

endmodule

// ===== hdl/c1ks_lfsr.sv =====
// Cipher register with its filter and feedback, one step per cycle while stepping is enabled.
module c1ks_lfsr (
	input  logic                       clk,
	input  logic                       arst_n,
	input  c1ks_pkg::lfsr_ctl_t        ctl,
	input  logic [c1ks_pkg::KEY_W-1:0] key,
	input  logic                       in_bit,
	input  logic                       enc,
	output logic                       ks_bit
);
	import c1ks_pkg::*;

	logic [HALF_W-1:0] odd_q;
	logic [HALF_W-1:0] even_q;
	logic              fb;

	// Keystream bit and feedback bit of the current state.
	always_comb begin
		ks_bit = filter_bit(odd_q[19:0]);
		fb     = (ks_bit & enc) ^ in_bit ^ (^(TAPS_ODD & odd_q)) ^ (^(TAPS_EVEN & even_q));
	end

	// Clear, key load, or one shift followed by the swap of the halves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q  <= '0;
			even_q <= '0;
		end else if (ctl.clear) begin
			odd_q  <= '0;
			even_q <= '0;
		end else if (ctl.load) begin
			odd_q  <= key_odd(key);
			even_q <= key_even(key);
		end else if (ctl.step) begin
			odd_q  <= {even_q[HALF_W-2:0], fb};
			even_q <= odd_q;
		end
	end

endmodule

// ===== hdl/c1ks_serial.sv =====
// Serial feed and keystream shift registers and the result formatting.
module c1ks_serial (
	input  logic                        clk,
	input  c1ks_pkg::ser_ctl_t          ctl,
	input  logic [2:0]                  op,
	input  logic [c1ks_pkg::DATA_W-1:0] feed_in,
	input  logic [c1ks_pkg::DATA_W-1:0] xor_data,
	input  logic                        ks_bit,
	output logic                        feed_bit,
	output logic [c1ks_pkg::DATA_W-1:0] result
);
	import c1ks_pkg::*;

	logic [DATA_W-1:0] feed_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] dat_q;
	logic [2:0]        op_q;

	// Words are fed with the most significant byte first, so the bytes are
	// reversed on entry; then every operation shifts out from bit 0.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			feed_q <= (op == OP_WORD) ? byte_swap(feed_in) : feed_in;
			dat_q  <= xor_data;
			op_q   <= op;
			acc_q  <= '0;
		end else if (ctl.shift) begin
			feed_q <= {1'b0, feed_q[DATA_W-1:1]};
			acc_q  <= {ks_bit, acc_q[DATA_W-1:1]};
		end
	end

	assign feed_bit = feed_q[0];

	// Keystream bits collect from the top; pick them out at the op width.
	always_comb begin
		unique case (op_q)
			OP_BIT:  result = {{(DATA_W-1){1'b0}}, acc_q[DATA_W-1] ^ dat_q[0]};
			OP_BYTE: result = {{(DATA_W-8){1'b0}}, acc_q[DATA_W-1:DATA_W-8] ^ dat_q[7:0]};
			OP_WORD: result = byte_swap(acc_q) ^ dat_q;
			default: result = '0;
		endcase
	end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the Crypto1 keystream unit with a bit-level cipher predictor.
module tb_top;
	import c1ks_pkg::*;

	// Codes that the block must treat as no-ops.
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

	// Settle time after draining, longer than a word operation, before touching the key.
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [KEY_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [2:0]          op;
	logic [DATA_W-1:0]   feed_in;
	logic                encrypted_feedback;
	logic [DATA_W-1:0]   xor_data;
	logic                out_valid;
	logic                out_stall;
	logic [DATA_W-1:0]   data_out;

	// Predictor copy of the key and the cipher register.
	logic [KEY_W-1:0]    key_shadow;
	logic [HALF_W-1:0]   odd_st;
	logic [HALF_W-1:0]   even_st;

	logic [DATA_W-1:0]   keystream_q[$];
	int                  mismatch_count;
	int                  idle_pct;
	int                  stall_left;
	int                  quiet_cycles;

	crypto1_keystream_cipher_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.op                 (op),
		.feed_in            (feed_in),
		.encrypted_feedback (encrypted_feedback),
		.xor_data           (xor_data),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.data_out           (data_out)
	);

	always #5 clk = ~clk;

	// Nonlinear filter: five 4-input table lookups feed one 5-input table.
	function automatic logic ks_filter(input logic [HALF_W-1:0] x);
		logic [4:0] sel;
		sel[4] = FILT_A[x[3:0] + 4];
		sel[3] = FILT_B[x[7:4] + 3];
		sel[2] = FILT_C[x[11:8] + 2];
		sel[1] = FILT_D[x[15:12] + 1];
		sel[0] = FILT_E[x[19:16]];
		return FILT_OUT[sel];
	endfunction

	// One cipher step: emit the filter bit, shift feedback into even, swap halves.
	function automatic logic cipher_clock(input logic in_bit, input logic enc);
		logic              ks;
		logic              fb;
		logic [HALF_W-1:0] prev_odd;
		ks       = ks_filter(odd_st);
		fb       = (ks & enc) ^ in_bit ^ (^(TAPS_ODD & odd_st)) ^ (^(TAPS_EVEN & even_st));
		prev_odd = odd_st;
		odd_st   = {even_st[HALF_W-2:0], fb};
		even_st  = prev_odd;
		return ks;
	endfunction

	// Advances the predicted register by one transaction and returns its data_out.
	function automatic logic [DATA_W-1:0] cipher_predict(input logic [2:0] o,
		input logic [DATA_W-1:0] f, input logic e, input logic [DATA_W-1:0] d);
		logic [DATA_W-1:0] ks;
		int                p;
		int                pos;
		ks = '0;
		case (o)
			OP_CLEAR: begin
				odd_st  = '0;
				even_st = '0;
			end
			OP_LOAD: begin
				// Key bit b sits at interleaved position b xor 7; even positions are the odd half.
				for (int b = 0; b < KEY_W; b++) begin
					p = b ^ 7;
					if (p[0]) begin
						even_st[p >> 1] = key_shadow[b];
					end else begin
						odd_st[p >> 1] = key_shadow[b];
					end
				end
			end
			OP_BIT: begin
				ks[0] = cipher_clock(f[0], e) ^ d[0];
			end
			OP_BYTE: begin
				for (int i = 0; i < 8; i++) begin
					ks[i] = cipher_clock(f[i], e);
				end
				ks = (ks ^ d) & 32'h0000_00FF;
			end
			OP_WORD: begin
				// Bytes go most significant first, bits within a byte from the bottom.
				for (int i = 0; i < DATA_W; i++) begin
					pos     = i ^ 24;
					ks[pos] = cipher_clock(f[pos], e);
				end
				ks = ks ^ d;
			end
			default: begin
			end
		endcase
		return ks;
	endfunction

	// Sends one transaction after an optional idle burst and records its expected result.
	task automatic send_item(input logic [2:0] o, input logic [DATA_W-1:0] f,
		input logic e, input logic [DATA_W-1:0] d);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid           <= 1'b1;
		op                 <= o;
		feed_in            <= f;
		encrypted_feedback <= e;
		xor_data           <= d;
		do @(posedge clk); while (in_stall);
		keystream_q.push_back(cipher_predict(o, f, e, d));
	endtask

	// Lets the block drain completely and settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (keystream_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the sector key while the block is idle.
	task automatic write_key(input logic [KEY_W-1:0] k);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		key_shadow  = k;
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Extremes of every field, every operation, unused codes and ignored upper bits.
	task automatic test_directed();
		idle_pct = 30;
		send_item(OP_WORD, 32'h0000_0000, 1'b0, 32'h0000_0000);
		write_key({KEY_W{1'b1}});
		send_item(OP_LOAD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
		send_item(OP_BYTE, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
		send_item(OP_BIT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_BIT, 32'h0000_0000, 1'b0, 32'h0000_0000);
		for (int c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++) begin
			send_item(3'(c), 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		end
		send_item(OP_WORD, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_WORD, 32'h0000_0000, 1'b0, 32'h0000_0000);
		send_item(OP_BYTE, 32'h0000_00FF, 1'b1, 32'h0000_0000);
		write_key('0);
		send_item(OP_LOAD, 32'h0000_0000, 1'b0, 32'h0000_0000);
		send_item(OP_WORD, 32'h0000_0000, 1'b0, 32'h0000_0000);
		write_key(48'hA5A5_5A5A_C33C);
		send_item(OP_LOAD, 32'h0000_0000, 1'b0, 32'h0000_0000);
		send_item(OP_WORD, 32'h1234_5678, 1'b1, 32'h8765_4321);
		send_item(OP_BYTE, 32'hFFFF_FF00, 1'b0, 32'hFFFF_FF00);
		send_item(OP_BIT, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
		send_item(OP_WORD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
	endtask

	// Mostly keyed streams of bit, byte and word steps, with clears and unused codes as noise.
	task automatic test_random_traffic(input logic [KEY_W-1:0] k, input int count,
		input int idle);
		int          r;
		logic [2:0]  o;
		write_key(k);
		idle_pct = idle;
		send_item(OP_LOAD, $urandom, 1'($urandom), $urandom);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				o = OP_CLEAR;
			end else if (r < 8) begin
				o = OP_LOAD;
			end else if (r < 28) begin
				o = OP_BIT;
			end else if (r < 53) begin
				o = OP_BYTE;
			end else if (r < 95) begin
				o = OP_WORD;
			end else begin
				o = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
			end
			send_item(o, $urandom, 1'($urandom), $urandom);
		end
	endtask

	// Output side: score every result, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (keystream_q.size() == 0) begin
					$error("data_out: unexpected result %08h, expected none", data_out);
					mismatch_count++;
				end else if (data_out !== keystream_q[0]) begin
					$error("data_out: expected %08h, actual %08h", keystream_q[0], data_out);
					mismatch_count++;
					void'(keystream_q.pop_front());
				end else begin
					void'(keystream_q.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 5) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("crypto1_keystream_cipher_unit regression: fail");
			$finish;
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		in_valid           = 1'b0;
		op                 = OP_CLEAR;
		feed_in            = '0;
		encrypted_feedback = 1'b0;
		xor_data           = '0;
		key_shadow         = '0;
		odd_st             = '0;
		even_st            = '0;
		mismatch_count     = 0;
		idle_pct           = 0;
		quiet_cycles       = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(random_key(), RANDOM_ITEMS, 25);
		test_random_traffic('0, RANDOM_ITEMS, 40);
		test_random_traffic({KEY_W{1'b1}}, RANDOM_ITEMS, 25);
		test_random_traffic(random_key(), RANDOM_ITEMS, 0);
		test_random_traffic(random_key(), RANDOM_ITEMS, 30);
		// Last stretch runs with neither side idling.
		test_random_traffic(random_key(), RANDOM_ITEMS, 0);

		wait_idle();
		if (mismatch_count == 0 && keystream_q.size() == 0) begin
			$display("crypto1_keystream_cipher_unit regression: pass");
		end else begin
			$display("crypto1_keystream_cipher_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== crypto1_keystream_cipher_unit.f =====
hdl/c1ks_pkg.sv
hdl/c1ks_lfsr.sv
hdl/c1ks_serial.sv
hdl/crypto1_keystream_cipher_unit.sv
dv/tb_top.sv
